// ----- rtl/core/rgb_to_nv12_nv21_converter_macros.svh -----
// Assertion macros for the RGB to NV12/NV21 converter.
// Used by the top level only; needs nothing else.
`ifndef RGB_TO_NV12_NV21_CONVERTER_MACROS_SVH
`define RGB_TO_NV12_NV21_CONVERTER_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define RNV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define RNV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rnv_pkg.sv -----
// Shared types, constants and helpers of the RGB to NV12/NV21 converter.
// Depends on nothing; every other file except the macro header imports it.
`timescale 1ns / 1ps

package rnv_pkg;

  // Field and register widths
  localparam int PIX_W    = 8;
  localparam int SIZE_W   = 13;
  localparam int EFF_W    = 14;
  localparam int LADDR_W  = 24;
  localparam int CADDR_W  = 25;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;
  localparam int PROD_W   = 2 * EFF_W;

  // Default frame limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Register reset values
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic              ORDER_RESET  = 1'b0;

  // Decoupling queue
  localparam int QUEUE_DEPTH = 4;

  // BT.601 studio-range coefficients (magnitudes; signs are in the datapath)
  localparam int COEF_Y_R    = 66;
  localparam int COEF_Y_G    = 129;
  localparam int COEF_Y_B    = 25;
  localparam int COEF_CB_R   = 38;
  localparam int COEF_CB_G   = 74;
  localparam int COEF_C_MAIN = 112;
  localparam int COEF_CR_G   = 94;
  localparam int COEF_CR_B   = 18;
  localparam int ROUND_BIAS  = 128;
  localparam int LUMA_OFFSET = 16;
  // Rounding plus 128 chroma offset moved ahead of the shift: 128*256 + 128
  localparam int CHROMA_BIAS = 32896;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CHROMA_ORDER = 2'd2
  } reg_idx_e;

  typedef enum logic {
    ORDER_NV12 = 1'b0,
    ORDER_NV21 = 1'b1
  } chroma_order_e;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [EFF_W-1:0]   eff_width;
    logic [EFF_W-1:0]   eff_height;
    logic [CADDR_W-1:0] frame_size;
    chroma_order_e      order;
    logic               restart;
  } cfg_t;

  // One classified pixel waiting for the back end
  typedef struct packed {
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic [LADDR_W-1:0] luma_address;
    logic               chroma_valid;
    logic [CADDR_W-1:0] chroma_offset;
    logic               frame_end;
    chroma_order_e      order;
  } item_t;

  // One finished result
  typedef struct packed {
    logic [PIX_W-1:0]   luma;
    logic [LADDR_W-1:0] luma_address;
    logic               chroma_valid;
    logic [PIX_W-1:0]   chroma_first;
    logic [PIX_W-1:0]   chroma_second;
    logic [CADDR_W-1:0] chroma_address;
    logic               frame_end;
  } result_t;

  // Zero reads as one, anything above the limit reads as the limit.
  function automatic logic [EFF_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                  logic [EFF_W-1:0] maxv);
    logic [EFF_W-1:0] ext;
    ext = EFF_W'(v);
    if (ext == '0) begin
      return EFF_W'(1);
    end else if (ext > maxv) begin
      return maxv;
    end
    return ext;
  endfunction

endpackage

// ----- rtl/core/rgb_to_nv12_nv21_converter.sv -----
// Channel   Direction  Handshake                Payload
// pixel     in         in_valid_i / in_stall_o  red_i, green_i, blue_i
// result    out        out_valid_o / out_stall_i luma, addresses, chroma pair, frame_end
// config    in/out     APB psel/penable/pready  paddr, pwdata, prdata
//
// One pixel per clock sustained unless the output stalls. An accepted pixel goes to
// a queue slot, then pops through the single constant-coefficient multiply-add stage
// into the back end's output register. A four-entry queue splits the pixel counters
// from the color math, so input stall rises only when the queue fills behind a
// stalled output. Reset clears the counters and the queue and loads 640x480, NV12.
//
// Top level of the RGB to NV12/NV21 converter.
// Depends on rnv_pkg, rnv_regs, rnv_front, rnv_queue, rnv_back and the macro header.
`timescale 1ns / 1ps
`include "rgb_to_nv12_nv21_converter_macros.svh"

module rgb_to_nv12_nv21_converter #(
  parameter int MAX_WIDTH  = rnv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rnv_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rnv_pkg::ADDR_W-1:0]    paddr,
  input  logic [rnv_pkg::DATA_W-1:0]    pwdata,
  output logic [rnv_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // Pixel input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rnv_pkg::PIX_W-1:0]     red_i,
  input  logic [rnv_pkg::PIX_W-1:0]     green_i,
  input  logic [rnv_pkg::PIX_W-1:0]     blue_i,
  // Result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rnv_pkg::PIX_W-1:0]     luma_o,
  output logic [rnv_pkg::LADDR_W-1:0]   luma_address_o,
  output logic                          chroma_valid_o,
  output logic [rnv_pkg::PIX_W-1:0]     chroma_first_o,
  output logic [rnv_pkg::PIX_W-1:0]     chroma_second_o,
  output logic [rnv_pkg::CADDR_W-1:0]   chroma_address_o,
  output logic                          frame_end_o
);
  import rnv_pkg::*;

  cfg_t    cfg;
  item_t   push_item, head_item;
  result_t res;
  logic    q_push, q_pop, q_empty, q_full;
  logic [$clog2(QUEUE_DEPTH):0] q_count;

  // Register bank: raw values for readback, clamped sizes for the datapath.
  rnv_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Front end: accept a pixel whenever the queue has room and tag it.
  rnv_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .red_i     (red_i),
    .green_i   (green_i),
    .blue_i    (blue_i),
    .q_push_o  (q_push),
    .q_item_o  (push_item),
    .q_full_i  (q_full)
  );

  // Hold tagged pixels while the output side stalls.
  rnv_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .pop_i  (q_pop),
    .item_o (head_item),
    .empty_o(q_empty),
    .full_o (q_full),
    .count_o(q_count)
  );

  // Back end: color math and the output register.
  rnv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_size_i(cfg.frame_size),
    .item_i      (head_item),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign luma_o           = res.luma;
  assign luma_address_o   = res.luma_address;
  assign chroma_valid_o   = res.chroma_valid;
  assign chroma_first_o   = res.chroma_first;
  assign chroma_second_o  = res.chroma_second;
  assign chroma_address_o = res.chroma_address;
  assign frame_end_o      = res.frame_end;

  // A push without a pop grows the queue by exactly one item.
  `RNV_ASSERT_NEXT(a_queue_grow, clk_i, rst_ni, q_push && !q_pop, q_count == $past(q_count) + 1'b1, "queue count did not grow on push")

  // Without a chroma pair, the pair fields read as zero.
  `RNV_ASSERT_NOW(a_chroma_zero, clk_i, rst_ni, out_valid_o && !chroma_valid_o, chroma_first_o == '0 && chroma_second_o == '0 && chroma_address_o == '0, "chroma fields nonzero without a pair")

  // Chroma pairs come only from even rows and even columns, so the luma address is even.
  `RNV_ASSERT_NOW(a_chroma_even, clk_i, rst_ni, out_valid_o && chroma_valid_o, !luma_address_o[0], "chroma pair on an odd luma address")

endmodule

// ----- rtl/core/rnv_regs.sv -----
// Configuration register bank with APB-style access.
// Depends on rnv_pkg; hands the clamped frame size and order to the datapath.
`timescale 1ns / 1ps

module rnv_regs #(
  parameter int MAX_WIDTH  = rnv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rnv_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rnv_pkg::ADDR_W-1:0]  paddr,
  input  logic [rnv_pkg::DATA_W-1:0]  pwdata,
  output logic [rnv_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output rnv_pkg::cfg_t               cfg_o
);
  import rnv_pkg::*;

  localparam logic [EFF_W-1:0] MaxW = EFF_W'(MAX_WIDTH);
  localparam logic [EFF_W-1:0] MaxH = EFF_W'(MAX_HEIGHT);

  logic [SIZE_W-1:0]  width_q, height_q;
  logic [EFF_W-1:0]   eff_width_q, eff_height_q;
  logic [CADDR_W-1:0] frame_size_q;
  logic [PROD_W-1:0]  size_prod;
  chroma_order_e      order_q;
  logic               wr_en;
  reg_idx_e           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= WIDTH_RESET;
      height_q     <= HEIGHT_RESET;
      eff_width_q  <= clamp_size(WIDTH_RESET, MaxW);
      eff_height_q <= clamp_size(HEIGHT_RESET, MaxH);
      order_q      <= chroma_order_e'(ORDER_RESET);
    end else if (wr_en) begin
      unique case (idx)
        REG_FRAME_WIDTH: begin
          width_q     <= pwdata[SIZE_W-1:0];
          eff_width_q <= clamp_size(pwdata[SIZE_W-1:0], MaxW);
        end
        REG_FRAME_HEIGHT: begin
          height_q     <= pwdata[SIZE_W-1:0];
          eff_height_q <= clamp_size(pwdata[SIZE_W-1:0], MaxH);
        end
        REG_CHROMA_ORDER: begin
          order_q <= chroma_order_e'(pwdata[0]);
        end
        default: begin
        end
      endcase
    end
  end

  // Frame size is registered from the registered clamped sizes; items reach the back end later.
  assign size_prod = PROD_W'(eff_width_q) * PROD_W'(eff_height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_size_q <= CADDR_W'(PROD_W'(clamp_size(WIDTH_RESET, MaxW)) *
                               PROD_W'(clamp_size(HEIGHT_RESET, MaxH)));
    end else begin
      frame_size_q <= size_prod[CADDR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(width_q);
      REG_FRAME_HEIGHT: prdata = DATA_W'(height_q);
      REG_CHROMA_ORDER: prdata = DATA_W'(order_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.eff_width  = eff_width_q;
    cfg_o.eff_height = eff_height_q;
    cfg_o.frame_size = frame_size_q;
    cfg_o.order      = order_q;
    cfg_o.restart    = wr_en && (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT);
  end

endmodule

// ----- rtl/core/rnv_front.sv -----
// Front end: accepts pixels, tracks row and column, tags each pixel with its addresses.
// Depends on rnv_pkg; feeds rnv_queue.
`timescale 1ns / 1ps

module rnv_front #(
  parameter int MAX_WIDTH  = rnv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rnv_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rnv_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [rnv_pkg::PIX_W-1:0]  red_i,
  input  logic [rnv_pkg::PIX_W-1:0]  green_i,
  input  logic [rnv_pkg::PIX_W-1:0]  blue_i,
  output logic                       q_push_o,
  output rnv_pkg::item_t             q_item_o,
  input  logic                       q_full_i
);
  import rnv_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT);

  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [LADDR_W-1:0] luma_q, luma_d;
  logic [CADDR_W-1:0] coff_q, coff_d;
  logic               last_col, last_row, cvalid, push;

  assign push       = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = push;

  assign last_col = EFF_W'(col_q) >= (cfg_i.eff_width - EFF_W'(1));
  assign last_row = EFF_W'(row_q) >= (cfg_i.eff_height - EFF_W'(1));
  assign cvalid   = !row_q[0] && !col_q[0];

  always_comb begin
    q_item_o.red           = red_i;
    q_item_o.green         = green_i;
    q_item_o.blue          = blue_i;
    q_item_o.luma_address  = luma_q;
    q_item_o.chroma_valid  = cvalid;
    q_item_o.chroma_offset = coff_q;
    q_item_o.frame_end     = last_col && last_row;
    q_item_o.order         = cfg_i.order;
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    luma_d = luma_q;
    coff_d = coff_q;
    priority if (cfg_i.restart) begin
      col_d  = '0;
      row_d  = '0;
      luma_d = '0;
      coff_d = '0;
    end else if (push) begin
      luma_d = luma_q + LADDR_W'(1);
      if (cvalid) begin
        coff_d = coff_q + CADDR_W'(2);
      end
      if (last_col) begin
        col_d = '0;
        if (last_row) begin
          row_d  = '0;
          luma_d = '0;
          coff_d = '0;
        end else begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      luma_q <= '0;
      coff_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      luma_q <= luma_d;
      coff_q <= coff_d;
    end
  end

endmodule

// ----- rtl/core/rnv_queue.sv -----
// Short FIFO of tagged pixels between front and back end.
// Depends on rnv_pkg for the item type and depth.
`timescale 1ns / 1ps

module rnv_queue (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  input  rnv_pkg::item_t                         item_i,
  input  logic                                   pop_i,
  output rnv_pkg::item_t                         item_o,
  output logic                                   empty_o,
  output logic                                   full_o,
  output logic [$clog2(rnv_pkg::QUEUE_DEPTH):0]  count_o
);
  import rnv_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = PtrW + 1;

  item_t           slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign count_o = count_q;
  assign item_o  = slot_q[rd_ptr_q];

  // Payload slots need no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/core/rnv_back.sv -----
// Back end: color math on the queue head and the output register.
// Depends on rnv_pkg; pops rnv_queue.
`timescale 1ns / 1ps

module rnv_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [rnv_pkg::CADDR_W-1:0]     frame_size_i,
  input  rnv_pkg::item_t                  item_i,
  input  logic                            q_empty_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rnv_pkg::result_t                res_o
);
  import rnv_pkg::*;

  localparam int SumW = 17;

  logic [SumW-1:0] y_sum, cb_sum, cr_sum;
  logic [PIX_W-1:0] cb, cr;
  result_t res_d, res_q;
  logic    valid_q;
  logic    pop;

  // Load the output register when it is empty or being drained.
  assign pop     = !q_empty_i && (!valid_q || !out_stall_i);
  assign q_pop_o = pop;

  always_comb begin
    y_sum  = SumW'(item_i.red)   * SumW'(COEF_Y_R)
           + SumW'(item_i.green) * SumW'(COEF_Y_G)
           + SumW'(item_i.blue)  * SumW'(COEF_Y_B)
           + SumW'(ROUND_BIAS);
    // Biased sums stay positive, so the floor is a plain shift.
    cb_sum = SumW'(item_i.blue) * SumW'(COEF_C_MAIN) + SumW'(CHROMA_BIAS)
           - SumW'(item_i.red)   * SumW'(COEF_CB_R)
           - SumW'(item_i.green) * SumW'(COEF_CB_G);
    cr_sum = SumW'(item_i.red) * SumW'(COEF_C_MAIN) + SumW'(CHROMA_BIAS)
           - SumW'(item_i.green) * SumW'(COEF_CR_G)
           - SumW'(item_i.blue)  * SumW'(COEF_CR_B);
    cb = cb_sum[15:8];
    cr = cr_sum[15:8];

    res_d.luma           = y_sum[15:8] + PIX_W'(LUMA_OFFSET);
    res_d.luma_address   = item_i.luma_address;
    res_d.chroma_valid   = item_i.chroma_valid;
    res_d.frame_end      = item_i.frame_end;
    res_d.chroma_first   = '0;
    res_d.chroma_second  = '0;
    res_d.chroma_address = '0;
    if (item_i.chroma_valid) begin
      res_d.chroma_first   = (item_i.order == ORDER_NV21) ? cr : cb;
      res_d.chroma_second  = (item_i.order == ORDER_NV21) ? cb : cr;
      res_d.chroma_address = frame_size_i + item_i.chroma_offset;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- tb/sv/tb_rgb_to_nv12_nv21_converter.sv -----
// Self-checking testbench for the RGB to NV12/NV21 converter top level.
// Depends on rnv_pkg and the converter RTL; every result is checked against a built-in predictor or a typed table row.
`timescale 1ns / 1ps

module tb_rgb_to_nv12_nv21_converter;
  import rnv_pkg::*;

  localparam int         RESET_CYCLES  = 12;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         RANDOM_ITEMS  = 500;
  localparam int         HOLD_CYCLES   = 64;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         MAX_REPORTS   = 10;
  localparam int         SIZE_FIELD    = 8191;
  // Index one past the register list; writes there must be dropped.
  localparam logic [1:0] REG_SPARE     = 2'd3;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_e;

  // One row of the directed table: either a pixel or a register write.
  typedef struct {
    step_kind_e        kind;
    logic [1:0]        sel;
    logic [31:0]       value;
    logic [PIX_W-1:0]  r;
    logic [PIX_W-1:0]  g;
    logic [PIX_W-1:0]  b;
    bit                typed;
    result_t           want;
  } step_t;

  // DUT connections
  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PIX_W-1:0]    red_i;
  logic [PIX_W-1:0]    green_i;
  logic [PIX_W-1:0]    blue_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PIX_W-1:0]    luma_o;
  logic [LADDR_W-1:0]  luma_address_o;
  logic                chroma_valid_o;
  logic [PIX_W-1:0]    chroma_first_o;
  logic [PIX_W-1:0]    chroma_second_o;
  logic [CADDR_W-1:0]  chroma_address_o;
  logic                frame_end_o;

  // Predictor copy of the registers and the raster position
  logic [SIZE_W-1:0]   width_reg;
  logic [SIZE_W-1:0]   height_reg;
  chroma_order_e       order_reg;
  logic [11:0]         col_cnt;
  logic [11:0]         row_cnt;
  logic [LADDR_W-1:0]  luma_ptr;
  logic [CADDR_W-1:0]  chroma_ptr;

  result_t             pending_results[$];
  step_t               plan[$];
  int                  err_cnt;
  int                  cycle_cnt;
  bit                  sparse;    // when clear, neither side inserts random gaps
  bit                  hold_req;  // ask the receiver for one long hold-off

  rgb_to_nv12_nv21_converter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .luma_o           (luma_o),
    .luma_address_o   (luma_address_o),
    .chroma_valid_o   (chroma_valid_o),
    .chroma_first_o   (chroma_first_o),
    .chroma_second_o  (chroma_second_o),
    .chroma_address_o (chroma_address_o),
    .frame_end_o      (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Zero counts as one, anything past the limit counts as the limit.
  function automatic int fit_size(logic [SIZE_W-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  // Rewind to the top of the frame; the chroma plane starts right after luma.
  function automatic void restart_frame();
    col_cnt    = '0;
    row_cnt    = '0;
    luma_ptr   = '0;
    chroma_ptr = CADDR_W'(fit_size(width_reg, MAX_WIDTH_DEF) *
                          fit_size(height_reg, MAX_HEIGHT_DEF));
  endfunction

  // floor((sum + 128) / 256) + 128, kept to one byte
  function automatic logic [PIX_W-1:0] chroma_byte(int sum);
    int biased;
    biased = sum + 32896;
    return biased[15:8];
  endfunction

  // Work out the result of one pixel and advance the raster position.
  function automatic result_t convert_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                            logic [PIX_W-1:0] b);
    int               w;
    int               h;
    int               ri;
    int               gi;
    int               bi;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic             even;
    logic             last_col;
    logic             last_row;
    result_t          res;
    w  = fit_size(width_reg, MAX_WIDTH_DEF);
    h  = fit_size(height_reg, MAX_HEIGHT_DEF);
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    cb = chroma_byte(-38 * ri - 74 * gi + 112 * bi);
    cr = chroma_byte(112 * ri - 94 * gi - 18 * bi);
    even     = !row_cnt[0] && !col_cnt[0];
    last_col = int'(col_cnt) >= w - 1;
    last_row = int'(row_cnt) >= h - 1;

    res.luma           = PIX_W'(((66 * ri + 129 * gi + 25 * bi + 128) >> 8) + 16);
    res.luma_address   = luma_ptr;
    res.chroma_valid   = even;
    res.chroma_first   = !even ? '0 : (order_reg == ORDER_NV21) ? cr : cb;
    res.chroma_second  = !even ? '0 : (order_reg == ORDER_NV21) ? cb : cr;
    res.chroma_address = even ? chroma_ptr : '0;
    res.frame_end      = last_col && last_row;

    luma_ptr = luma_ptr + 1'b1;
    if (even) chroma_ptr = chroma_ptr + 2'd2;
    if (last_col) begin
      col_cnt = '0;
      if (last_row) begin
        restart_frame();
      end else begin
        row_cnt = row_cnt + 1'b1;
      end
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return res;
  endfunction

  // Mirror a register write; a size write restarts the frame.
  function automatic void apply_register(logic [1:0] sel, logic [31:0] value);
    case (sel)
      REG_FRAME_WIDTH: begin
        width_reg = value[SIZE_W-1:0];
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = value[SIZE_W-1:0];
        restart_frame();
      end
      REG_CHROMA_ORDER: begin
        order_reg = chroma_order_e'(value[0]);
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders and random pickers
  // ---------------------------------------------------------------------------

  function automatic void add_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                    logic [PIX_W-1:0] b);
    step_t s;
    s.kind  = STEP_PIXEL;
    s.sel   = '0;
    s.value = '0;
    s.r     = r;
    s.g     = g;
    s.b     = b;
    s.typed = 1'b0;
    s.want  = '0;
    plan.push_back(s);
  endfunction

  // Pixel whose result is known by inspection.
  function automatic void add_known(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                    logic [PIX_W-1:0] b, int luma, int laddr, bit cv,
                                    int c1, int c2, int caddr, bit fe);
    add_pixel(r, g, b);
    plan[$].typed               = 1'b1;
    plan[$].want.luma           = PIX_W'(luma);
    plan[$].want.luma_address   = LADDR_W'(laddr);
    plan[$].want.chroma_valid   = cv;
    plan[$].want.chroma_first   = PIX_W'(c1);
    plan[$].want.chroma_second  = PIX_W'(c2);
    plan[$].want.chroma_address = CADDR_W'(caddr);
    plan[$].want.frame_end      = fe;
  endfunction

  function automatic void add_write(logic [1:0] sel, logic [31:0] value);
    add_pixel('0, '0, '0);
    plan[$].kind  = STEP_WRITE;
    plan[$].sel   = sel;
    plan[$].value = value;
  endfunction

  function automatic logic [PIX_W-1:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly tiny frames so frame ends come often; now and then zero, the limit,
  // values past the limit, a larger frame, and junk above the field.
  function automatic logic [31:0] pick_size(int limit);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'd0;
      1:       v = 32'($urandom_range(limit + 1, SIZE_FIELD));
      2:       v = 32'(limit);
      3:       v = 32'($urandom_range(10, 700));
      default: v = 32'($urandom_range(1, 9));
    endcase
    if ($urandom_range(0, 3) == 0) v[31:SIZE_W] = 19'($urandom);
    return v;
  endfunction

  task automatic note_failure(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers; every task starts and ends at a falling edge
  // ---------------------------------------------------------------------------

  // Write a register, then, unless it is the spare index, read it straight back in the next transfer.
  task automatic write_register(logic [1:0] sel, logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({sel, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_register(sel, value);
    @(negedge clk_i);
    if (sel == REG_SPARE) begin
      psel    <= 1'b0;
      penable <= 1'b0;
    end else begin
      // Keep psel high and turn the bus around into a read setup phase.
      pwrite  <= 1'b0;
      penable <= 1'b0;
      readback = (sel == REG_CHROMA_ORDER) ? 32'(value[0]) : 32'(value[SIZE_W-1:0]);
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata !== readback)
        note_failure($sformatf("register %0d reads %0h, expected %0h",
                               sel, prdata, readback));
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    @(negedge clk_i);
  endtask

  // Offer one pixel, after a random gap when sparse, and hold it until it is taken.
  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b,
                            bit typed, result_t want);
    int      gap;
    result_t predicted;
    gap = sparse ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    // Advance the predictor even for table rows with a typed result.
    predicted = convert_pixel(r, g, b);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every expected result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall before each result when sparse, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      n = sparse ? $urandom_range(0, 4) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_result
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: luma %0d at %0d",
                               luma_o, luma_address_o));
      end else begin
        want = pending_results.pop_front();
        if (luma_o !== want.luma || luma_address_o !== want.luma_address ||
            chroma_valid_o !== want.chroma_valid ||
            chroma_first_o !== want.chroma_first ||
            chroma_second_o !== want.chroma_second ||
            chroma_address_o !== want.chroma_address ||
            frame_end_o !== want.frame_end)
          note_failure($sformatf({"mismatch: expected y %0d @%0d cv %0b c %0d,%0d @%0d fe %0b;",
                                  " got y %0d @%0d cv %0b c %0d,%0d @%0d fe %0b"},
                                 want.luma, want.luma_address, want.chroma_valid,
                                 want.chroma_first, want.chroma_second,
                                 want.chroma_address, want.frame_end,
                                 luma_o, luma_address_o, chroma_valid_o,
                                 chroma_first_o, chroma_second_o,
                                 chroma_address_o, frame_end_o));
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int               random_sent;
    int               phase;
    int               n_items;
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;

    // Drive every input to a known value and hold reset.
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    red_i      = '0;
    green_i    = '0;
    blue_i     = '0;
    err_cnt    = 0;
    cycle_cnt  = 0;
    sparse     = 1'b1;
    hold_req   = 1'b0;

    // Predictor after reset: 640x480, NV12.
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    order_reg  = ORDER_NV12;
    restart_frame();

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Start from the reset frame: black, white, red and green
    // cover the luma and chroma extremes; odd columns carry no chroma.
    add_known(8'd0,   8'd0,   8'd0,   16,  0, 1, 128, 128, 307200, 0);
    add_known(8'd255, 8'd255, 8'd255, 235, 1, 0, 0,   0,   0,      0);
    add_known(8'd255, 8'd0,   8'd0,   82,  2, 1, 90,  240, 307202, 0);
    add_known(8'd0,   8'd255, 8'd0,   144, 3, 0, 0,   0,   0,      0);
    // Flip to NV21 mid-frame: the next pair comes Cr first, no restart.
    add_write(REG_CHROMA_ORDER, 32'(ORDER_NV21));
    add_known(8'd0,   8'd0,   8'd255, 41,  4, 1, 110, 240, 307204, 0);
    // Zero width counts as one and restarts the frame.
    add_write(REG_FRAME_WIDTH, 32'd0);
    add_pixel(8'd12, 8'd200, 8'd77);
    add_pixel(8'd128, 8'd64, 8'd32);
    // One-pixel frame: every pixel ends the frame and carries chroma.
    add_write(REG_FRAME_HEIGHT, 32'd0);
    add_known(8'd255, 8'd255, 8'd255, 235, 0, 1, 128, 128, 1, 1);
    add_known(8'd0,   8'd0,   8'd0,   16,  0, 1, 128, 128, 1, 1);
    // Width beyond the limit is held at the limit.
    add_write(REG_FRAME_WIDTH, 32'(SIZE_FIELD));
    add_pixel(8'd1, 8'd2, 8'd3);
    add_pixel(8'd254, 8'd1, 8'd127);
    // Full 3x2 NV12 frame with its wrap.
    add_write(REG_FRAME_WIDTH, 32'd3);
    add_write(REG_FRAME_HEIGHT, 32'd2);
    add_write(REG_CHROMA_ORDER, 32'(ORDER_NV12));
    add_pixel(8'd0, 8'd0, 8'd255);
    add_pixel(8'd255, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd255);
    add_pixel(8'd170, 8'd85, 8'd15);
    add_pixel(8'd255, 8'd255, 8'd255);
    // Write past the register list: dropped, the frame carries on.
    add_write(REG_SPARE, 32'd1);
    add_pixel(8'd85, 8'd170, 8'd240);
    add_write(REG_FRAME_HEIGHT, 32'd4097);
    add_pixel(8'd200, 8'd100, 8'd50);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        drain();
        write_register(plan[i].sel, plan[i].value);
      end else begin
        send_pixel(plan[i].r, plan[i].g, plan[i].b, plan[i].typed, plan[i].want);
      end
    end

    // Random part: phases of random settings, each followed by a burst of pixels.
    // Phases do not line up with frames, so size writes often land mid-frame.
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      if ($urandom_range(0, 2) == 0) write_register(REG_FRAME_WIDTH, pick_size(MAX_WIDTH_DEF));
      if ($urandom_range(0, 2) == 0)
        write_register(REG_FRAME_HEIGHT, pick_size(MAX_HEIGHT_DEF));
      if ($urandom_range(0, 3) == 0) write_register(REG_CHROMA_ORDER, 32'($urandom));
      if ($urandom_range(0, 9) == 0) write_register(REG_SPARE, 32'($urandom));
      sparse  = ($urandom_range(0, 3) != 0);
      n_items = $urandom_range(8, 40);
      if (phase == 3) begin
        // Back-to-back pixels against a long output hold-off: fill the block
        // until it stalls its input.
        sparse   = 1'b0;
        hold_req = 1'b1;
        n_items  = 40;
      end
      repeat (n_items) begin
        r = pick_byte();
        g = pick_byte();
        b = pick_byte();
        send_pixel(r, g, b, 1'b0, '0);
        random_sent++;
      end
      phase++;
    end

    drain();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
